[hw/rtl/free_look_camera_update_defines.svh]
// Assertion macros shared by the free-look camera RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef FREE_LOOK_CAMERA_UPDATE_DEFINES_SVH
`define FREE_LOOK_CAMERA_UPDATE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define FLC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define FLC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/flc_pkg.sv]
// Shared types and constants of the free-look camera block.
// No dependencies; used by the register, ROM, stage and top-level RTL files.
`default_nettype none

package flc_pkg;

  // Configuration port geometry
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Q1.14 one and the reset target z (1.0 in Q16.16)
  localparam logic signed [15:0] Q14_ONE     = 16'sd16384;
  localparam logic signed [31:0] AIM_Z_RESET = 32'sd65536;

  // Request kinds
  typedef enum logic [2:0] {
    KIND_MOTION   = 3'd0,
    KIND_FORWARD  = 3'd1,
    KIND_BACKWARD = 3'd2,
    KIND_LEFT     = 3'd3,
    KIND_RIGHT    = 3'd4,
    KIND_REINIT   = 3'd5
  } kind_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_EYE_X = 3'd0,
    REG_EYE_Y = 3'd1,
    REG_EYE_Z = 3'd2,
    REG_AIM_X = 3'd3,
    REG_AIM_Y = 3'd4,
    REG_AIM_Z = 3'd5
  } reg_idx_t;

  // Sine and cosine of one angle, Q1.14
  typedef struct packed {
    logic signed [15:0] s;
    logic signed [15:0] c;
  } trig_t;

  // Start pose loaded by reinit
  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] aim_x;
    logic signed [31:0] aim_y;
    logic signed [31:0] aim_z;
  } cfg_t;

  // Request entering the pose stage
  typedef struct packed {
    logic       valid;
    logic [2:0] kind;
  } stage_t;

endpackage

`default_nettype wire

[hw/rtl/flc_cmd_if.sv]
// Request channel of the free-look camera: kind and mouse deltas.
// No dependencies.
`default_nettype none

interface flc_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [11:0] delta_x;
  logic signed [11:0] delta_y;

  modport source (output valid, kind, delta_x, delta_y, input ready);
  modport sink   (input valid, kind, delta_x, delta_y, output ready);
endinterface

`default_nettype wire

[hw/rtl/flc_pose_if.sv]
// Result channel of the free-look camera: positions and vectors.
// No dependencies.
`default_nettype none

interface flc_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] eye_x;
  logic signed [31:0] eye_y;
  logic signed [31:0] eye_z;
  logic signed [31:0] aim_x;
  logic signed [31:0] aim_y;
  logic signed [31:0] aim_z;
  logic signed [15:0] fwd_x;
  logic signed [15:0] fwd_y;
  logic signed [15:0] fwd_z;
  logic signed [15:0] side_x;
  logic signed [15:0] side_z;

  modport source (output valid, eye_x, eye_y, eye_z, aim_x, aim_y, aim_z,
                  fwd_x, fwd_y, fwd_z, side_x, side_z, input ready);
  modport sink   (input valid, eye_x, eye_y, eye_z, aim_x, aim_y, aim_z,
                  fwd_x, fwd_y, fwd_z, side_x, side_z, output ready);
endinterface

`default_nettype wire

[hw/rtl/flc_cfg_regs.sv]
// APB-style start pose registers of the free-look camera.
// Depends on flc_pkg.
`default_nettype none

module flc_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [flc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [flc_pkg::DATA_W-1:0]  pwdata,
  output logic      [flc_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output flc_pkg::cfg_t                    start
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  // register writes; indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      start.eye_x <= '0;
      start.eye_y <= '0;
      start.eye_z <= '0;
      start.aim_x <= '0;
      start.aim_y <= '0;
      start.aim_z <= flc_pkg::AIM_Z_RESET;
    end else if (wr_en) begin
      unique case (idx)
        flc_pkg::REG_EYE_X: start.eye_x <= pwdata;
        flc_pkg::REG_EYE_Y: start.eye_y <= pwdata;
        flc_pkg::REG_EYE_Z: start.eye_z <= pwdata;
        flc_pkg::REG_AIM_X: start.aim_x <= pwdata;
        flc_pkg::REG_AIM_Y: start.aim_y <= pwdata;
        flc_pkg::REG_AIM_Z: start.aim_z <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      flc_pkg::REG_EYE_X: prdata = start.eye_x;
      flc_pkg::REG_EYE_Y: prdata = start.eye_y;
      flc_pkg::REG_EYE_Z: prdata = start.eye_z;
      flc_pkg::REG_AIM_X: prdata = start.aim_x;
      flc_pkg::REG_AIM_Y: prdata = start.aim_y;
      flc_pkg::REG_AIM_Z: prdata = start.aim_z;
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/flc_trig_rom.sv]
// Sine/cosine ROM indexed by angle step, two registered read ports.
// Depends on flc_pkg. Contents are computed at elaboration.
`default_nettype none

module flc_trig_rom #(
  parameter int ANGLE_STEPS = 720
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [$clog2(ANGLE_STEPS)-1:0] yaw_addr,
  input  wire logic [$clog2(ANGLE_STEPS)-1:0] pitch_addr,
  output flc_pkg::trig_t                      yaw_sc,
  output flc_pkg::trig_t                      pitch_sc
);

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Quarter-wave sine, Taylor series to 9th order in Q30, rounded to Q1.14
  function automatic logic [15:0] quarter_sine(input logic [14:0] q);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned r;
    x  = (64'(q) * HALF_PI_Q30) >> 14;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    r  = (s + 64'd32768) >> 16;
    if (r > 64'd16384) r = 64'd16384;
    return 16'(r);
  endfunction

  // Full-wave sine of a 16-bit phase by quadrant folding
  function automatic logic signed [15:0] phase_sine(input logic [15:0] ph);
    logic [14:0] q;
    logic [15:0] v;
    q = {1'b0, ph[13:0]};
    unique case (ph[15:14])
      2'd0: v = quarter_sine(q);
      2'd1: v = quarter_sine(15'd16384 - q);
      2'd2: v = 16'(-quarter_sine(q));
      2'd3: v = 16'(-quarter_sine(15'd16384 - q));
    endcase
    return v;
  endfunction

  flc_pkg::trig_t rom [ANGLE_STEPS];

  // table: angle step -> rounded phase -> sine and cosine
  for (genvar g = 0; g < ANGLE_STEPS; g++) begin : g_entry
    localparam int unsigned PHASE = ((g * 65536) + (ANGLE_STEPS / 2)) / ANGLE_STEPS;
    localparam logic [15:0] PH_SIN = 16'(PHASE);
    localparam logic [15:0] PH_COS = 16'(PHASE + 16384);
    localparam logic signed [15:0] SIN_V = phase_sine(PH_SIN);
    localparam logic signed [15:0] COS_V = phase_sine(PH_COS);
    assign rom[g] = '{s: SIN_V, c: COS_V};
  end

  // registered reads
  always_ff @(posedge clk) begin
    if (en) begin
      yaw_sc   <= rom[yaw_addr];
      pitch_sc <= rom[pitch_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/flc_angle_stage.sv]
// Request input register, delta reduction and yaw/pitch update.
// Depends on flc_pkg, flc_cmd_if and the assertion macro header.
`default_nettype none
`include "free_look_camera_update_defines.svh"

module flc_angle_stage #(
  parameter int ANGLE_STEPS = 720
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  flc_cmd_if.sink                              cmd,
  input  wire logic                            s3_ready,
  output flc_pkg::stage_t                      s3,
  output logic                                 rom_en,
  output logic [$clog2(ANGLE_STEPS)-1:0]       yaw_addr,
  output logic [$clog2(ANGLE_STEPS)-1:0]       pitch_addr
);

  localparam int YAW_W       = $clog2(ANGLE_STEPS);
  localparam int PITCH_LIMIT = (89 * ANGLE_STEPS) / 360;
  localparam int PITCH_W     = $clog2(PITCH_LIMIT + 1) + 1;
  localparam int NUM_WRAP    = 4095 / ANGLE_STEPS;
  localparam int DX_BIAS_MOD = 2048 % ANGLE_STEPS;
  localparam int T_W         = YAW_W + 2;

  localparam logic signed [T_W-1:0] YAW_MOD  = T_W'(ANGLE_STEPS);
  localparam logic signed [T_W-1:0] YAW_BIAS = T_W'(DX_BIAS_MOD);
  localparam logic signed [13:0]    P_MAX    = 14'(PITCH_LIMIT);
  localparam logic signed [13:0]    P_MIN    = -P_MAX;
  localparam logic signed [13:0]    P_STEPS  = 14'(ANGLE_STEPS);

  // pipeline registers
  logic               s1_valid;
  logic [2:0]         s1_kind;
  logic signed [11:0] s1_dx;
  logic signed [11:0] s1_dy;
  logic               s2_valid;
  logic [2:0]         s2_kind;
  logic [YAW_W-1:0]   s2_um;
  logic signed [11:0] s2_dy;

  // angle state
  logic [YAW_W-1:0]          yaw;
  logic signed [PITCH_W-1:0] pitch;
  logic [YAW_W-1:0]          yaw_next;
  logic signed [PITCH_W-1:0] pitch_next;

  logic s1_free;
  logic s2_free;
  logic s2_fire;

  logic [11:0]             dx_u;
  logic [11:0]             wrap_sub;
  logic [YAW_W-1:0]        um;
  logic signed [T_W-1:0]   yaw_sum;
  logic signed [T_W-1:0]   yaw_wrap;
  logic [YAW_W-1:0]        yaw_calc;
  logic signed [13:0]      pitch_diff;
  logic signed [13:0]      pitch_clamp;
  logic signed [PITCH_W-1:0] pitch_calc;

  // stage handshake: a stage takes a request when empty or draining
  assign s2_free   = !s2_valid || s3_ready;
  assign s1_free   = !s1_valid || s2_free;
  assign s2_fire   = s2_valid && s3_ready;
  assign cmd.ready = s1_free;
  assign rom_en    = s3_ready;

  // dx + 2048 reduced modulo the angle steps by parallel compares
  always_comb begin
    dx_u     = {~s1_dx[11], s1_dx[10:0]};
    wrap_sub = '0;
    for (int j = 1; j <= NUM_WRAP; j++) begin
      if (dx_u >= 12'(j * ANGLE_STEPS)) wrap_sub = 12'(j * ANGLE_STEPS);
    end
    um = YAW_W'(dx_u - wrap_sub);
  end

  // yaw - dx mod steps: sum lies in (-steps, 2*steps)
  always_comb begin
    yaw_sum = T_W'(yaw) + YAW_BIAS - T_W'(s2_um);
    if (yaw_sum < 0) begin
      yaw_wrap = yaw_sum + YAW_MOD;
    end else if (yaw_sum >= YAW_MOD) begin
      yaw_wrap = yaw_sum - YAW_MOD;
    end else begin
      yaw_wrap = yaw_sum;
    end
    yaw_calc = YAW_W'(yaw_wrap);
  end

  // pitch - dy, clamped to the pitch limit
  always_comb begin
    pitch_diff = 14'(pitch) - 14'(s2_dy);
    if (pitch_diff > P_MAX) begin
      pitch_clamp = P_MAX;
    end else if (pitch_diff < P_MIN) begin
      pitch_clamp = P_MIN;
    end else begin
      pitch_clamp = pitch_diff;
    end
    pitch_calc = PITCH_W'(pitch_clamp);
    yaw_addr   = yaw_calc;
    if (pitch_clamp < 0) begin
      pitch_addr = YAW_W'(pitch_clamp + P_STEPS);
    end else begin
      pitch_addr = YAW_W'(pitch_clamp);
    end
  end

  // next angle state
  always_comb begin
    yaw_next   = yaw;
    pitch_next = pitch;
    if (s2_fire) begin
      unique case (s2_kind)
        flc_pkg::KIND_MOTION: begin
          yaw_next   = yaw_calc;
          pitch_next = pitch_calc;
        end
        flc_pkg::KIND_REINIT: begin
          yaw_next   = '0;
          pitch_next = '0;
        end
        default: ;
      endcase
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3.valid  <= 1'b0;
      yaw       <= '0;
      pitch     <= '0;
    end else begin
      if (s1_free)  s1_valid <= cmd.valid;
      if (s2_free)  s2_valid <= s1_valid;
      if (s3_ready) s3.valid <= s2_valid;
      yaw   <= yaw_next;
      pitch <= pitch_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_kind <= cmd.kind;
      s1_dx   <= cmd.delta_x;
      s1_dy   <= cmd.delta_y;
    end
    if (s2_free) begin
      s2_kind <= s1_kind;
      s2_um   <= um;
      s2_dy   <= s1_dy;
    end
    if (s3_ready) s3.kind <= s2_kind;
  end

  `FLC_ASSERT_NOW(a_yaw_range, clk, rst, 1'b1, yaw < YAW_W'(ANGLE_STEPS - 1) || yaw == YAW_W'(ANGLE_STEPS - 1), "yaw out of range")
  `FLC_ASSERT_NOW(a_pitch_range, clk, rst, 1'b1, (14'(pitch) <= P_MAX) && (14'(pitch) >= P_MIN), "pitch past limit")
  `FLC_ASSERT_NEXT(a_reinit_zero, clk, rst, s2_fire && (s2_kind == flc_pkg::KIND_REINIT), (yaw == '0) && (pitch == '0), "reinit left angles nonzero")

endmodule

`default_nettype wire

[hw/rtl/flc_pose_stage.sv]
// Pose update: forward/left vectors, eye and target moves, result register.
// Depends on flc_pkg, flc_pose_if and the assertion macro header.
`default_nettype none
`include "free_look_camera_update_defines.svh"

module flc_pose_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  flc_pkg::stage_t      s3,
  input  flc_pkg::trig_t       yaw_sc,
  input  flc_pkg::trig_t       pitch_sc,
  input  flc_pkg::cfg_t        start,
  output logic                 s3_ready,
  flc_pose_if.source           pose
);

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] aim_x;
    logic signed [31:0] aim_y;
    logic signed [31:0] aim_z;
    logic signed [15:0] fwd_x;
    logic signed [15:0] fwd_y;
    logic signed [15:0] fwd_z;
    logic signed [15:0] side_x;
    logic signed [15:0] side_z;
  } pose_t;

  // Q16.16 add with saturation to 32 bits
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [21:0] b);
    logic signed [33:0] s;
    s = 34'(a) + 34'(b);
    if (s > 34'sd2147483647) return 32'sh7FFFFFFF;
    if (s < -34'sd2147483648) return 32'sh80000000;
    return 32'(s);
  endfunction

  // Q1.14 vector component times 40 (ten steps of four)
  function automatic logic signed [21:0] times40(input logic signed [15:0] f);
    return (22'(f) <<< 5) + (22'(f) <<< 3);
  endfunction

  // Q1.14 vector component times 4
  function automatic logic signed [21:0] times4(input logic signed [15:0] f);
    return 22'(f) <<< 2;
  endfunction

  // Q1.14 product, rounded half away from zero
  function automatic logic signed [15:0] mul_q14(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic signed [31:0] p;
    logic [31:0]        mag;
    logic [31:0]        r;
    p   = a * b;
    mag = p[31] ? 32'(-p) : 32'(p);
    r   = (mag + 32'd8192) >> 14;
    return p[31] ? 16'(-r) : 16'(r);
  endfunction

  pose_t cur;
  pose_t nxt;
  logic  out_valid;
  logic  fire;

  logic signed [15:0] fwd_mx;
  logic signed [15:0] fwd_mz;
  logic signed [31:0] eye_x_lr;
  logic signed [31:0] eye_z_lr;
  logic signed [21:0] fwd_dx;
  logic signed [21:0] fwd_dy;
  logic signed [21:0] fwd_dz;
  logic signed [21:0] side_dx;
  logic signed [21:0] side_dz;

  assign s3_ready = !out_valid || pose.ready;
  assign fire     = s3.valid && s3_ready;

  // rotated forward vector from the ROM outputs
  assign fwd_mx = mul_q14(pitch_sc.c, yaw_sc.s);
  assign fwd_mz = mul_q14(pitch_sc.c, yaw_sc.c);

  // move offsets, sign chosen by direction
  always_comb begin
    if (s3.kind == flc_pkg::KIND_BACKWARD) begin
      fwd_dx = -times40(cur.fwd_x);
      fwd_dy = -times40(cur.fwd_y);
      fwd_dz = -times40(cur.fwd_z);
    end else begin
      fwd_dx = times40(cur.fwd_x);
      fwd_dy = times40(cur.fwd_y);
      fwd_dz = times40(cur.fwd_z);
    end
    if (s3.kind == flc_pkg::KIND_RIGHT) begin
      side_dx = -times40(cur.side_x);
      side_dz = -times40(cur.side_z);
    end else begin
      side_dx = times40(cur.side_x);
      side_dz = times40(cur.side_z);
    end
    eye_x_lr = sat_add(cur.eye_x, side_dx);
    eye_z_lr = sat_add(cur.eye_z, side_dz);
  end

  // next pose per request kind; unused kinds leave it as is
  always_comb begin
    nxt = cur;
    unique case (s3.kind)
      flc_pkg::KIND_MOTION: begin
        nxt.fwd_x  = fwd_mx;
        nxt.fwd_y  = pitch_sc.s;
        nxt.fwd_z  = fwd_mz;
        nxt.side_x = yaw_sc.c;
        nxt.side_z = 16'(-yaw_sc.s);
        nxt.aim_x  = sat_add(cur.eye_x, times4(fwd_mx));
        nxt.aim_y  = sat_add(cur.eye_y, times4(pitch_sc.s));
        nxt.aim_z  = sat_add(cur.eye_z, times4(fwd_mz));
      end
      flc_pkg::KIND_FORWARD, flc_pkg::KIND_BACKWARD: begin
        nxt.eye_x = sat_add(cur.eye_x, fwd_dx);
        nxt.eye_y = sat_add(cur.eye_y, fwd_dy);
        nxt.eye_z = sat_add(cur.eye_z, fwd_dz);
        nxt.aim_x = sat_add(cur.aim_x, fwd_dx);
        nxt.aim_y = sat_add(cur.aim_y, fwd_dy);
        nxt.aim_z = sat_add(cur.aim_z, fwd_dz);
      end
      flc_pkg::KIND_LEFT, flc_pkg::KIND_RIGHT: begin
        nxt.eye_x = eye_x_lr;
        nxt.eye_z = eye_z_lr;
        nxt.aim_x = sat_add(eye_x_lr, times4(cur.fwd_x));
        nxt.aim_y = sat_add(cur.eye_y, times4(cur.fwd_y));
        nxt.aim_z = sat_add(eye_z_lr, times4(cur.fwd_z));
      end
      flc_pkg::KIND_REINIT: begin
        nxt.eye_x  = start.eye_x;
        nxt.eye_y  = start.eye_y;
        nxt.eye_z  = start.eye_z;
        nxt.aim_x  = start.aim_x;
        nxt.aim_y  = start.aim_y;
        nxt.aim_z  = start.aim_z;
        nxt.fwd_x  = '0;
        nxt.fwd_y  = '0;
        nxt.fwd_z  = flc_pkg::Q14_ONE;
        nxt.side_x = flc_pkg::Q14_ONE;
        nxt.side_z = '0;
      end
      default: ;
    endcase
  end

  // pose state doubles as the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      cur.eye_x  <= '0;
      cur.eye_y  <= '0;
      cur.eye_z  <= '0;
      cur.aim_x  <= '0;
      cur.aim_y  <= '0;
      cur.aim_z  <= '0;
      cur.fwd_x  <= '0;
      cur.fwd_y  <= '0;
      cur.fwd_z  <= flc_pkg::Q14_ONE;
      cur.side_x <= flc_pkg::Q14_ONE;
      cur.side_z <= '0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        cur       <= nxt;
      end else if (pose.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign pose.valid  = out_valid;
  assign pose.eye_x  = cur.eye_x;
  assign pose.eye_y  = cur.eye_y;
  assign pose.eye_z  = cur.eye_z;
  assign pose.aim_x  = cur.aim_x;
  assign pose.aim_y  = cur.aim_y;
  assign pose.aim_z  = cur.aim_z;
  assign pose.fwd_x  = cur.fwd_x;
  assign pose.fwd_y  = cur.fwd_y;
  assign pose.fwd_z  = cur.fwd_z;
  assign pose.side_x = cur.side_x;
  assign pose.side_z = cur.side_z;

  `FLC_ASSERT_NEXT(a_fire_valid, clk, rst, fire, out_valid, "result not presented after update")
  `FLC_ASSERT_NEXT(a_reinit_vec, clk, rst, fire && (s3.kind == flc_pkg::KIND_REINIT), (cur.fwd_z == flc_pkg::Q14_ONE) && (cur.side_x == flc_pkg::Q14_ONE), "reinit vectors wrong")
  `FLC_ASSERT_NOW(a_fwd_y_unit, clk, rst, 1'b1, (cur.fwd_y <= flc_pkg::Q14_ONE) && (cur.fwd_y >= -flc_pkg::Q14_ONE), "forward y exceeds unit")

endmodule

`default_nettype wire

[hw/rtl/free_look_camera_update.sv]
// Free-look camera update. A request passes the input register, the reduction
// register, the stage-3 and ROM output registers and the result register in turn.
// Throughput: one request per cycle while the result side is ready. A result-side
// stall holds the pose stage; ready drops once the s1 and s2 registers are full.
// Reset: start pose registers to (0,0,0)/(0,0,1.0); angles zero, eye and target
// zero, forward (0,0,1), left (1,0); no result pending.
`default_nettype none

module free_look_camera_update #(
  parameter int ANGLE_STEPS = 720
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  flc_cmd_if.sink                          cmd,
  flc_pose_if.source                       pose,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [flc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [flc_pkg::DATA_W-1:0]  pwdata,
  output logic      [flc_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int YAW_W = $clog2(ANGLE_STEPS);

  flc_pkg::cfg_t   start;
  flc_pkg::stage_t s3;
  flc_pkg::trig_t  yaw_sc;
  flc_pkg::trig_t  pitch_sc;
  logic            s3_ready;
  logic            rom_en;
  logic [YAW_W-1:0] yaw_addr;
  logic [YAW_W-1:0] pitch_addr;

  // start pose registers
  flc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .start   (start)
  );

  // input registers and angle update
  flc_angle_stage #(.ANGLE_STEPS(ANGLE_STEPS)) u_angle (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .s3_ready   (s3_ready),
    .s3         (s3),
    .rom_en     (rom_en),
    .yaw_addr   (yaw_addr),
    .pitch_addr (pitch_addr)
  );

  // sine/cosine lookup
  flc_trig_rom #(.ANGLE_STEPS(ANGLE_STEPS)) u_rom (
    .clk        (clk),
    .en         (rom_en),
    .yaw_addr   (yaw_addr),
    .pitch_addr (pitch_addr),
    .yaw_sc     (yaw_sc),
    .pitch_sc   (pitch_sc)
  );

  // pose update and result register
  flc_pose_stage u_pose (
    .clk      (clk),
    .rst      (rst),
    .s3       (s3),
    .yaw_sc   (yaw_sc),
    .pitch_sc (pitch_sc),
    .start    (start),
    .s3_ready (s3_ready),
    .pose     (pose)
  );

endmodule

`default_nettype wire
